// File: src/fsp_pkg.sv
package fsp_pkg;

  // Store depth and derived address width
  localparam int unsigned MEM_WORDS = 1024;
  localparam int unsigned ADDR_W    = $clog2(MEM_WORDS);
  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned REG_W     = $clog2(REG_COUNT);

  // Opcodes (word bits 31..22)
  localparam logic [9:0] OP_ADD  = 10'd0;
  localparam logic [9:0] OP_NAND = 10'd1;
  localparam logic [9:0] OP_LW   = 10'd2;
  localparam logic [9:0] OP_SW   = 10'd3;
  localparam logic [9:0] OP_BEQ  = 10'd4;
  localparam logic [9:0] OP_HALT = 10'd6;

  localparam logic [31:0] NOOP_WORD = 32'h01c0_0000;

  // Item actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic             vld;
    logic [REG_W-1:0] idx;
  } dest_t;

  function automatic logic [9:0] op_of(logic [31:0] w);
    return w[31:22];
  endfunction

  function automatic logic [REG_W-1:0] ra_of(logic [31:0] w);
    return w[21:19];
  endfunction

  function automatic logic [REG_W-1:0] rb_of(logic [31:0] w);
    return w[18:16];
  endfunction

  // Destination register of a writer instruction
  function automatic dest_t dest_of(logic [31:0] w);
    dest_t d;
    d.vld = 1'b0;
    d.idx = '0;
    if (op_of(w) == OP_ADD || op_of(w) == OP_NAND) begin
      d.vld = 1'b1;
      d.idx = w[2:0];
    end else if (op_of(w) == OP_LW) begin
      d.vld = 1'b1;
      d.idx = ra_of(w);
    end
    return d;
  endfunction

  // Word address modulo the store depth
  function automatic logic [ADDR_W-1:0] wrap_addr(logic [31:0] a);
    return ADDR_W'(a % 32'(MEM_WORDS));
  endfunction

endpackage

// File: src/five_stage_pipeline_cpu_step.sv
// Five-stage core (fetch, decode, execute, memory, writeback) for the eight-opcode
// machine. Each input beat is either a load (write one word into both the instruction
// and the data store) or a tick (advance the whole pipeline one step unless halted).
// One beat is taken per cycle while the output register is empty or being taken, and
// its result beat appears in the output register on the next cycle. The instruction
// store, data store and register file are synchronous memories read ahead at the
// addresses the next machine state needs, with a bypass for the word written in that
// same cycle. After reset a clearing pass zeroes all stores and takes no input beat.
module five_stage_pipeline_cpu_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic        [9:0]  address_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               halted_o,
  output logic        [15:0] pc_o,
  output logic        [31:0] cycles_o,
  output logic        [31:0] fetched_o,
  output logic signed [31:0] retired_o,
  output logic        [31:0] branches_o,
  output logic        [31:0] mispredicts_o,
  output logic               reg_write_enable_o,
  output logic        [2:0]  reg_write_index_o,
  output logic signed [31:0] reg_write_data_o
);

  localparam int unsigned AW = fsp_pkg::ADDR_W;
  localparam int unsigned RW = fsp_pkg::REG_W;

  // Memories
  logic [31:0] imem [fsp_pkg::MEM_WORDS];
  logic [31:0] dmem [fsp_pkg::MEM_WORDS];
  logic [31:0] rf   [fsp_pkg::REG_COUNT];

  // Pipeline state
  logic [15:0] pc_q, pc_d;
  logic [31:0] fd_i_q, fd_i_d;
  logic [15:0] fd_pc_q, fd_pc_d;
  logic [31:0] de_i_q, de_i_d;
  logic [15:0] de_pc_q, de_pc_d;
  logic [31:0] de_a_q, de_a_d, de_b_q, de_b_d;
  logic [15:0] de_off_q, de_off_d;
  logic [31:0] em_i_q, em_i_d;
  logic [15:0] em_t_q, em_t_d;
  logic [31:0] em_alu_q, em_alu_d, em_sd_q, em_sd_d;
  logic [31:0] mw_i_q, mw_i_d, mw_d_q, mw_d_d;
  logic [31:0] wb_i_q, wb_i_d, wb_d_q, wb_d_d;
  logic [31:0] cyc_q, cyc_d, fetch_q, fetch_d, br_q, br_d, mis_q, mis_d;
  logic        halt_q, halt_d;

  // Clearing pass
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  // Read data and bypass
  logic [31:0]   im_rdata_q, dm_rdata_q, rfa_rdata_q, rfb_rdata_q;
  logic          im_byp_q, dm_byp_q, rfa_byp_q, rfb_byp_q;
  logic [31:0]   im_bypd_q, dm_bypd_q, rf_bypd_q;
  logic [31:0]   im_rd, dm_rd, rfa_rd, rfb_rd;

  // Write ports
  logic          im_we, dm_we, rf_we;
  logic [AW-1:0] im_waddr, dm_waddr;
  logic [RW-1:0] rf_waddr;
  logic [31:0]   im_wdata, dm_wdata, rf_wdata;
  logic [AW-1:0] im_raddr, dm_raddr;
  logic [RW-1:0] rfa_raddr, rfb_raddr;

  logic        fire, exec_en;
  logic        st_en;
  logic [31:0] st_data;
  logic [AW-1:0] st_addr;
  logic        wr_en;
  logic [RW-1:0] wr_idx;
  logic [31:0] wr_data;

  logic out_valid_q;

  assign in_ready_o = !clr_q && (!out_valid_q || out_ready_i);
  assign fire       = in_valid_i && in_ready_o;
  assign exec_en    = fire && action_i == fsp_pkg::ACT_TICK && !halt_q;

  assign im_rd  = im_byp_q  ? im_bypd_q : im_rdata_q;
  assign dm_rd  = dm_byp_q  ? dm_bypd_q : dm_rdata_q;
  assign rfa_rd = rfa_byp_q ? rf_bypd_q : rfa_rdata_q;
  assign rfb_rd = rfb_byp_q ? rf_bypd_q : rfb_rdata_q;

  // One machine tick
  always_comb begin
    logic [31:0] i, a, b;
    logic [9:0]  k;
    logic        uses_a, uses_b, stall;
    fsp_pkg::dest_t dw, dm;
    pc_d = pc_q; fd_i_d = fd_i_q; fd_pc_d = fd_pc_q;
    de_i_d = de_i_q; de_pc_d = de_pc_q; de_a_d = de_a_q; de_b_d = de_b_q;
    de_off_d = de_off_q;
    em_i_d = em_i_q; em_t_d = em_t_q; em_alu_d = em_alu_q; em_sd_d = em_sd_q;
    mw_i_d = mw_i_q; mw_d_d = mw_d_q; wb_i_d = wb_i_q; wb_d_d = wb_d_q;
    cyc_d = cyc_q; fetch_d = fetch_q; br_d = br_q; mis_d = mis_q; halt_d = halt_q;
    st_en = 1'b0; st_addr = '0; st_data = em_sd_q;
    wr_en = 1'b0; wr_idx = '0; wr_data = '0;
    i = '0; k = '0; a = '0; b = '0;
    uses_a = 1'b0; uses_b = 1'b0; stall = 1'b0;
    dw = '0; dm = '0;
    if (exec_en) begin
      // fetch
      fd_i_d  = im_rd;
      pc_d    = pc_q + 16'd1;
      fd_pc_d = pc_q + 16'd1;

      // decode
      i = fd_i_q; k = fsp_pkg::op_of(i);
      de_a_d = '0; de_b_d = '0; de_off_d = '0;
      if (k == fsp_pkg::OP_ADD || k == fsp_pkg::OP_NAND || k == fsp_pkg::OP_BEQ ||
          k == fsp_pkg::OP_SW) begin
        de_a_d = rfa_rd;
        de_b_d = rfb_rd;
      end else if (k == fsp_pkg::OP_LW) begin
        de_b_d = rfb_rd;
      end
      if (k == fsp_pkg::OP_LW || k == fsp_pkg::OP_SW || k == fsp_pkg::OP_BEQ) begin
        de_off_d = i[15:0];
      end
      de_i_d  = i;
      de_pc_d = fd_pc_q;

      // execute
      i = de_i_q; k = fsp_pkg::op_of(i);
      uses_a = k == fsp_pkg::OP_ADD || k == fsp_pkg::OP_NAND || k == fsp_pkg::OP_BEQ ||
               k == fsp_pkg::OP_SW;
      uses_b = uses_a || k == fsp_pkg::OP_LW;
      stall  = fsp_pkg::op_of(em_i_q) == fsp_pkg::OP_LW &&
               ((uses_a && fsp_pkg::ra_of(i) == fsp_pkg::ra_of(em_i_q)) ||
                (uses_b && fsp_pkg::rb_of(i) == fsp_pkg::ra_of(em_i_q)));
      dw = fsp_pkg::dest_of(wb_i_q);
      dm = fsp_pkg::dest_of(mw_i_q);
      if (stall) begin
        // hold front end, refresh held operands, insert a bubble
        pc_d = pc_q; fd_i_d = fd_i_q; fd_pc_d = fd_pc_q;
        de_i_d = de_i_q; de_pc_d = de_pc_q; de_off_d = de_off_q;
        de_a_d = de_a_q; de_b_d = de_b_q;
        if (dw.vld) begin
          if (uses_a && fsp_pkg::ra_of(i) == dw.idx) de_a_d = wb_d_q;
          if (uses_b && fsp_pkg::rb_of(i) == dw.idx) de_b_d = wb_d_q;
        end
        em_i_d = fsp_pkg::NOOP_WORD; em_t_d = '0; em_alu_d = '0; em_sd_d = '0;
      end else begin
        a = de_a_q; b = de_b_q;
        // forward, closest latch first
        if (uses_a) begin
          if ((fsp_pkg::op_of(em_i_q) == fsp_pkg::OP_ADD ||
               fsp_pkg::op_of(em_i_q) == fsp_pkg::OP_NAND) &&
              em_i_q[2:0] == fsp_pkg::ra_of(i)) a = em_alu_q;
          else if (dm.vld && dm.idx == fsp_pkg::ra_of(i)) a = mw_d_q;
          else if (dw.vld && dw.idx == fsp_pkg::ra_of(i)) a = wb_d_q;
        end
        if (uses_b) begin
          if ((fsp_pkg::op_of(em_i_q) == fsp_pkg::OP_ADD ||
               fsp_pkg::op_of(em_i_q) == fsp_pkg::OP_NAND) &&
              em_i_q[2:0] == fsp_pkg::rb_of(i)) b = em_alu_q;
          else if (dm.vld && dm.idx == fsp_pkg::rb_of(i)) b = mw_d_q;
          else if (dw.vld && dw.idx == fsp_pkg::rb_of(i)) b = wb_d_q;
        end
        em_t_d = de_pc_q; em_alu_d = '0; em_sd_d = '0;
        if (k == fsp_pkg::OP_ADD) begin
          em_alu_d = a + b;
        end else if (k == fsp_pkg::OP_NAND) begin
          em_alu_d = ~(a & b);
        end else if (k == fsp_pkg::OP_LW || k == fsp_pkg::OP_SW) begin
          em_alu_d = b + {{16{de_off_q[15]}}, de_off_q};
          em_sd_d  = a;
        end else if (k == fsp_pkg::OP_BEQ) begin
          em_t_d   = de_pc_q + de_off_q;
          em_alu_d = a - b;
        end
        em_i_d  = i;
        fetch_d = fetch_q + 32'd1;
      end
      cyc_d = cyc_q + 32'd1;

      // memory
      i = em_i_q; k = fsp_pkg::op_of(i);
      mw_d_d = '0;
      if (k == fsp_pkg::OP_ADD || k == fsp_pkg::OP_NAND) begin
        mw_d_d = em_alu_q;
      end else if (k == fsp_pkg::OP_SW) begin
        st_en   = 1'b1;
        st_addr = fsp_pkg::wrap_addr(em_alu_q);
      end else if (k == fsp_pkg::OP_LW) begin
        mw_d_d = dm_rd;
      end else if (k == fsp_pkg::OP_BEQ) begin
        br_d = br_q + 32'd1;
        if (em_alu_q == 32'd0) begin
          // taken: redirect and flush three latches
          pc_d = em_t_q;
          fd_i_d = fsp_pkg::NOOP_WORD; fd_pc_d = '0;
          de_i_d = fsp_pkg::NOOP_WORD; de_pc_d = '0; de_a_d = '0; de_b_d = '0;
          de_off_d = '0;
          em_i_d = fsp_pkg::NOOP_WORD; em_t_d = '0; em_alu_d = '0; em_sd_d = '0;
          mis_d = mis_q + 32'd1;
        end
      end

      // writeback
      if (dm.vld) begin
        wr_en   = 1'b1;
        wr_idx  = dm.idx;
        wr_data = mw_d_q;
      end
      wb_i_d = mw_i_q; wb_d_d = mw_d_q;
      mw_i_d = em_i_q;

      if (fsp_pkg::op_of(em_i_q) == fsp_pkg::OP_HALT) begin
        halt_d  = 1'b1;
        fetch_d = fetch_d - 32'd3;
      end
    end
  end

  // Memory ports: clearing pass, load beat or pipeline
  always_comb begin
    im_we = 1'b0; im_waddr = clr_addr_q; im_wdata = '0;
    dm_we = 1'b0; dm_waddr = clr_addr_q; dm_wdata = '0;
    rf_we = 1'b0; rf_waddr = clr_addr_q[RW-1:0]; rf_wdata = '0;
    if (clr_q) begin
      im_we = 1'b1; dm_we = 1'b1; rf_we = 1'b1;
    end else if (fire && action_i == fsp_pkg::ACT_LOAD) begin
      im_we = 1'b1; im_waddr = fsp_pkg::wrap_addr({22'd0, address_i});
      im_wdata = value_i;
      dm_we = 1'b1; dm_waddr = fsp_pkg::wrap_addr({22'd0, address_i});
      dm_wdata = value_i;
    end else begin
      dm_we = st_en; dm_waddr = st_addr; dm_wdata = st_data;
      rf_we = wr_en; rf_waddr = wr_idx; rf_wdata = wr_data;
    end
  end

  // Read ahead at the addresses of the next state
  assign im_raddr  = fsp_pkg::wrap_addr({16'd0, pc_d});
  assign dm_raddr  = fsp_pkg::wrap_addr(em_alu_d);
  assign rfa_raddr = fsp_pkg::ra_of(fd_i_d);
  assign rfb_raddr = fsp_pkg::rb_of(fd_i_d);

  always_ff @(posedge clk_i) begin
    if (im_we) imem[im_waddr] <= im_wdata;
    if (dm_we) dmem[dm_waddr] <= dm_wdata;
    if (rf_we) rf[rf_waddr]   <= rf_wdata;
    im_rdata_q  <= imem[im_raddr];
    dm_rdata_q  <= dmem[dm_raddr];
    rfa_rdata_q <= rf[rfa_raddr];
    rfb_rdata_q <= rf[rfb_raddr];
    im_bypd_q   <= im_wdata;
    dm_bypd_q   <= dm_wdata;
    rf_bypd_q   <= rf_wdata;
  end

  // Bypass flags for a read that meets a write to the same entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      im_byp_q  <= 1'b0;
      dm_byp_q  <= 1'b0;
      rfa_byp_q <= 1'b0;
      rfb_byp_q <= 1'b0;
    end else begin
      im_byp_q  <= im_we && im_waddr == im_raddr;
      dm_byp_q  <= dm_we && dm_waddr == dm_raddr;
      rfa_byp_q <= rf_we && rf_waddr == rfa_raddr;
      rfb_byp_q <= rf_we && rf_waddr == rfb_raddr;
    end
  end

  // Advance the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(fsp_pkg::MEM_WORDS - 1)) clr_q <= 1'b0;
    end
  end

  // Pipeline latches and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0; fd_i_q <= fsp_pkg::NOOP_WORD; fd_pc_q <= '0;
      de_i_q <= fsp_pkg::NOOP_WORD; de_pc_q <= '0; de_a_q <= '0; de_b_q <= '0;
      de_off_q <= '0;
      em_i_q <= fsp_pkg::NOOP_WORD; em_t_q <= '0; em_alu_q <= '0; em_sd_q <= '0;
      mw_i_q <= fsp_pkg::NOOP_WORD; mw_d_q <= '0;
      wb_i_q <= fsp_pkg::NOOP_WORD; wb_d_q <= '0;
      cyc_q <= '0; fetch_q <= '0; br_q <= '0; mis_q <= '0; halt_q <= 1'b0;
    end else begin
      pc_q <= pc_d; fd_i_q <= fd_i_d; fd_pc_q <= fd_pc_d;
      de_i_q <= de_i_d; de_pc_q <= de_pc_d; de_a_q <= de_a_d; de_b_q <= de_b_d;
      de_off_q <= de_off_d;
      em_i_q <= em_i_d; em_t_q <= em_t_d; em_alu_q <= em_alu_d; em_sd_q <= em_sd_d;
      mw_i_q <= mw_i_d; mw_d_q <= mw_d_d;
      wb_i_q <= wb_i_d; wb_d_q <= wb_d_d;
      cyc_q <= cyc_d; fetch_q <= fetch_d; br_q <= br_d; mis_q <= mis_d;
      halt_q <= halt_d;
    end
  end

  // Output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      halted_o           <= halt_d;
      pc_o               <= pc_d;
      cycles_o           <= cyc_d;
      fetched_o          <= fetch_d;
      retired_o          <= fetch_d - ({mis_d[30:0], 1'b0} + mis_d);
      branches_o         <= br_d;
      mispredicts_o      <= mis_d;
      reg_write_enable_o <= wr_en;
      reg_write_index_o  <= wr_idx;
      reg_write_data_o   <= wr_data;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
